[rtl/rsqs_pkg.sv]
// Shared constants for the range square-root update / range-sum block.
// Used by rtl/range_sqrt_update_sum_query.sv and the tb; depends on nothing.
package rsqs_pkg;

	localparam int DEPTH = 1024;              // entries, indexed 1..DEPTH
	localparam int AW    = $clog2(DEPTH);     // memory address width
	localparam int IW    = 11;                // index field width
	localparam int VW    = 40;                // entry value width
	localparam int SW    = 50;                // sum width

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_SQRT = 2'd1;
	localparam logic [1:0] OP_SUM  = 2'd2;

endpackage

[rtl/rsqs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module rsqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/range_sqrt_update_sum_query.sv]
// Top level of the range square-root update / range-sum block.
// Depends on rtl/rsqs_pkg.sv and rtl/rsqs_ram.sv.
//
// The block holds DEPTH unsigned 40-bit entries (indices 1..DEPTH) in one
// synchronous RAM. A load request writes one entry, at left_index if that
// lies in [1,DEPTH]. A sqrt request replaces every entry of [left,right] by
// its floor square root; a sum request walks [left,right] and returns the
// 50-bit total as one result. A reversed range is swapped, then cut to
// [1,DEPTH]. Each entry walked passes a RAM read state, then an accumulate
// or test state; an entry above 1 under a sqrt request then runs the
// restoring square-root loop (one result bit per cycle, 20 steps over 40
// bits, then a finishing state) and a write state.
// After reset a clearing pass writes zero to every entry with s_tready low.
// A finished sum sits in an output register, so the block returns to idle
// while the result waits; a second sum stalls at its end until the first is
// taken. Operation code 3 is accepted and ignored.
module range_sqrt_update_sum_query (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] operation, [12:2] left_index, [23:13] right_index, [63:24] load_value
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [49:0] range_sum, [55:50] zero
	output logic [55:0] m_tdata
);

	// sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_DAT  = 3'd4;
	localparam logic [2:0] ST_SQ   = 3'd5;
	localparam logic [2:0] ST_WR   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam int AW = rsqs_pkg::AW;
	localparam int IW = rsqs_pkg::IW;
	localparam int VW = rsqs_pkg::VW;
	localparam int SW = rsqs_pkg::SW;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    op_q;
	logic [IW-1:0] cur_q;     // entry being walked / loaded
	logic [IW-1:0] hi_q;      // last entry of the cut range
	logic [VW-1:0] val_q;     // load value
	logic [SW-1:0] acc_q;     // running sum
	logic [VW-1:0] rem_q;     // square-root remainder
	logic [VW-1:0] root_q;    // square-root partial result
	logic [VW-1:0] bit_q;     // square-root one-hot trial bit
	logic          m_valid_q;
	logic [SW-1:0] sum_q;

	// request fields
	logic [1:0]    in_op;
	logic [IW-1:0] in_left, in_right, lo_sw, hi_sw, lo_cut, hi_cut;
	logic [VW-1:0] in_val;

	assign in_op    = s_tdata[1:0];
	assign in_left  = s_tdata[12:2];
	assign in_right = s_tdata[23:13];
	assign in_val   = s_tdata[63:24];

	// swap, then cut to [1,DEPTH]
	always_comb begin
		lo_sw  = (in_left > in_right) ? in_right : in_left;
		hi_sw  = (in_left > in_right) ? in_left : in_right;
		lo_cut = (lo_sw == '0) ? IW'(1) : lo_sw;
		hi_cut = (hi_sw > IW'(rsqs_pkg::DEPTH)) ? IW'(rsqs_pkg::DEPTH) : hi_sw;
	end

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// RAM ports; entry k lives at address k-1
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [VW-1:0] ram_wdata, ram_rdata;
	logic [IW-1:0] cur_m1;

	assign cur_m1    = cur_q - IW'(1);
	assign ram_raddr = cur_m1[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_m1[AW-1:0];
		ram_wdata = root_q;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_LOAD: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			ST_WR:   ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	rsqs_ram #(
		.WIDTH(VW),
		.DEPTH(rsqs_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one restoring square-root step
	logic [VW:0] trial;
	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	logic last_entry;
	assign last_entry = (cur_q == hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// ST_OUT refills the output register itself
			if (m_valid_q && m_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(rsqs_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q  <= in_op;
						val_q <= in_val;
						acc_q <= '0;
						hi_q  <= hi_cut;
						priority if (in_op == rsqs_pkg::OP_LOAD) begin
							cur_q <= in_left;
							if (in_left != '0 && in_left <= IW'(rsqs_pkg::DEPTH)) begin
								state_q <= ST_LOAD;
							end
						end else if (in_op == rsqs_pkg::OP_SQRT) begin
							cur_q <= lo_cut;
							if (lo_cut <= hi_cut) begin
								state_q <= ST_RD;
							end
						end else if (in_op == rsqs_pkg::OP_SUM) begin
							cur_q   <= lo_cut;
							state_q <= (lo_cut <= hi_cut) ? ST_RD : ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_RD:   state_q <= ST_DAT;
				ST_DAT: begin
					if (op_q == rsqs_pkg::OP_SUM) begin
						acc_q <= acc_q + SW'(ram_rdata);
						if (last_entry) begin
							state_q <= ST_OUT;
						end else begin
							cur_q   <= cur_q + IW'(1);
							state_q <= ST_RD;
						end
					end else if (ram_rdata > VW'(1)) begin
						rem_q   <= ram_rdata;
						root_q  <= '0;
						bit_q   <= VW'(1) << (VW - 2);
						state_q <= ST_SQ;
					end else if (last_entry) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= cur_q + IW'(1);
						state_q <= ST_RD;
					end
				end
				ST_SQ: begin
					if (bit_q == '0) begin
						state_q <= ST_WR;
					end else begin
						if ({1'b0, rem_q} >= trial) begin
							rem_q  <= rem_q - trial[VW-1:0];
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				ST_WR: begin
					if (last_entry) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= cur_q + IW'(1);
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					// wait until the output register is free
					if (!m_valid_q || m_tready) begin
						sum_q     <= acc_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, sum_q};

endmodule

[tb/range_sqrt_update_sum_query_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for range_sqrt_update_sum_query: directed and random
// load/sqrt/sum requests against an in-bench model; depends on all rtl/ files.
module range_sqrt_update_sum_query_test;

	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [39:0] load_value;
		logic [10:0] right_index;
		logic [10:0] left_index;
		logic [1:0]  operation;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	range_sqrt_update_sum_query dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// model of the entry array, index 1..DEPTH
	logic [rsqs_pkg::VW-1:0] entry_model [0:rsqs_pkg::DEPTH];
	logic [rsqs_pkg::SW-1:0] sum_expected [$];
	request_t                pending_requests [$];
	int                      mismatch_count = 0;
	bit                      stimulus_done = 0;
	bit                      hold_for_drain = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic void add_request(input request_t r);
		pending_requests = {pending_requests, r};
	endfunction

	function automatic void add_expected(input logic [rsqs_pkg::SW-1:0] s);
		sum_expected = {sum_expected, s};
	endfunction

	function automatic logic [rsqs_pkg::VW-1:0] floor_sqrt(input logic [rsqs_pkg::VW-1:0] v);
		logic [rsqs_pkg::VW-1:0] root;
		root = '0;
		for (int b = rsqs_pkg::VW / 2 - 1; b >= 0; b--) begin
			logic [rsqs_pkg::VW-1:0] trial;
			trial = root | (40'd1 << b);
			if ({40'd0, trial} * trial <= {40'd0, v})
				root = trial;
		end
		return root;
	endfunction

	// applies one request to the model, queues the sum if one is due
	task automatic apply_request(input request_t r);
		int lo, hi, t;
		logic [rsqs_pkg::SW-1:0] acc;
		lo = r.left_index;
		hi = r.right_index;
		if (r.operation == rsqs_pkg::OP_LOAD) begin
			if (lo >= 1 && lo <= rsqs_pkg::DEPTH)
				entry_model[lo] = r.load_value;
		end else if (r.operation != OP_NONE) begin
			if (lo > hi) begin
				t = lo; lo = hi; hi = t;
			end
			if (lo < 1) lo = 1;
			if (hi > rsqs_pkg::DEPTH) hi = rsqs_pkg::DEPTH;
			acc = '0;
			for (int i = lo; i <= hi; i++) begin
				if (r.operation == rsqs_pkg::OP_SQRT)
					entry_model[i] = floor_sqrt(entry_model[i]);
				else
					acc = acc + rsqs_pkg::SW'(entry_model[i]);
			end
			if (r.operation == rsqs_pkg::OP_SUM)
				add_expected(acc);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatch_count++;
	endtask

	function automatic request_t make_request(input logic [1:0] op, input int lo,
			input int hi, input logic [39:0] v);
		request_t r;
		r.operation = op;
		r.left_index = 11'(lo);
		r.right_index = 11'(hi);
		r.load_value = v;
		return r;
	endfunction

	function automatic logic [39:0] random_value();
		case ($urandom_range(0, 3))
			0: return 40'($urandom_range(0, 3));
			1: return 40'($urandom_range(0, 1000));
			default: return 40'({$urandom, $urandom});
		endcase
	endfunction

	// small ranges mostly, occasional full sweeps
	function automatic int random_index();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 2047);
			1: return $urandom_range(1, 1024);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(request_t'(s_tdata));
				void'(pending_requests.pop_front());
				send_gap = $urandom_range(0, 6);
			end
			if (s_tvalid && !s_tready) begin
				// keep holding
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (hold_for_drain || pending_requests.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_requests[0];
			end
		end
	end

	// monitor
	int take_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sum_expected.size() == 0)
					report_mismatch($sformatf("unexpected sum %0d",
						m_tdata[rsqs_pkg::SW-1:0]));
				else begin
					logic [rsqs_pkg::SW-1:0] want;
					want = sum_expected.pop_front();
					if (m_tdata[rsqs_pkg::SW-1:0] !== want)
						report_mismatch($sformatf("range_sum got %0d want %0d",
							m_tdata[rsqs_pkg::SW-1:0], want));
					if (m_tdata[55:rsqs_pkg::SW] !== '0)
						report_mismatch("padding bits not zero");
				end
				take_gap = $urandom_range(0, 6);
			end
			if (take_gap > 0) begin
				take_gap--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	initial begin
		for (int i = 0; i <= rsqs_pkg::DEPTH; i++) entry_model[i] = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, reversed and cut ranges, unused code
		add_request(make_request(rsqs_pkg::OP_SUM, 1, 1024, 0));
		add_request(make_request(rsqs_pkg::OP_LOAD, 1, 0, 40'hFF_FFFF_FFFF));
		add_request(make_request(rsqs_pkg::OP_LOAD, 1024, 2047, 40'hFF_FFFF_FFFF));
		add_request(make_request(rsqs_pkg::OP_LOAD, 0, 5, 40'h12345));
		add_request(make_request(rsqs_pkg::OP_LOAD, 2047, 5, 40'h12345));
		add_request(make_request(rsqs_pkg::OP_LOAD, 1025, 5, 7));
		add_request(make_request(rsqs_pkg::OP_LOAD, 2, 0, 1));
		add_request(make_request(rsqs_pkg::OP_LOAD, 3, 0, 2));
		add_request(make_request(rsqs_pkg::OP_SUM, 1024, 1, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 0, 2047, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 0, 0, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 2047, 1500, 0));
		add_request(make_request(OP_NONE, 1, 1024, 40'hAA_AAAA_AAAA));
		add_request(make_request(rsqs_pkg::OP_SQRT, 2047, 0, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 1, 1024, 0));
		add_request(make_request(rsqs_pkg::OP_SQRT, 1, 3, 0));
		add_request(make_request(rsqs_pkg::OP_SQRT, 0, 0, 0));
		add_request(make_request(rsqs_pkg::OP_SQRT, 1500, 2047, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 3, 1, 0));
		add_request(make_request(rsqs_pkg::OP_SQRT, 1, 1024, 0));
		add_request(make_request(rsqs_pkg::OP_SUM, 1, 1024, 0));

		for (int n = 0; n < 270; n++) begin
			int k;
			k = $urandom_range(0, 19);
			if (k < 9)
				add_request(make_request(rsqs_pkg::OP_LOAD, $urandom_range(1, 40),
					$urandom_range(0, 2047), random_value()));
			else if (k < 13)
				add_request(make_request(rsqs_pkg::OP_SQRT, random_index(),
					random_index(), 40'({$urandom, $urandom})));
			else if (k < 19)
				add_request(make_request(rsqs_pkg::OP_SUM, random_index(),
					random_index(), 40'({$urandom, $urandom})));
			else
				add_request(make_request(
					k[0] ? OP_NONE : rsqs_pkg::OP_LOAD, random_index(), random_index(),
					random_value()));
			if (n == 140) begin
				// let the queue shrink before going on
				wait (pending_requests.size() <= 100);
			end
		end

		wait (pending_requests.size() == 150);
		hold_for_drain = 1;
		wait (sum_expected.size() == 0 && !s_tvalid);
		repeat (30000) @(posedge clk);
		hold_for_drain = 0;

		wait (pending_requests.size() == 0 && sum_expected.size() == 0);
		repeat (30000) @(posedge clk);
		if (mismatch_count == 0 && sum_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
rtl/rsqs_pkg.sv
rtl/rsqs_ram.sv
rtl/range_sqrt_update_sum_query.sv
tb/range_sqrt_update_sum_query_test.sv
